FILE: hdl/sha_pkg.sv
// ============================================================================
// sha_pkg: shared types and constants for the SHA-256 stream hasher
// Holds the initial hash values, round constants and the queue entry type.
// ============================================================================
package sha_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } item_t;

    localparam int QueueDepth = 4;
    localparam int QueueAw    = 2;

    function automatic word_t init_word(input logic [2:0] idx);
        word_t r;
        case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    localparam word_t RoundK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: hdl/sha_in_if.sv
// ============================================================================
// sha_in_if: input byte channel
// Valid/ready channel carrying one optional message byte and an end mark.
// ============================================================================
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, data_byte, byte_present, end_of_message, input ready);
    modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

FILE: hdl/sha_out_if.sv
// ============================================================================
// sha_out_if: digest word channel
// Valid/ready channel carrying one digest word, its index and a last flag.
// ============================================================================
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: hdl/sha_queue.sv
// ============================================================================
// sha_queue: input item queue
// Small FIFO that decouples the accepting front from the hashing engine.
// ============================================================================
module sha_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sha_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output sha_pkg::item_t pop_item,
    output logic           empty
);
    sha_pkg::item_t                 mem_reg [sha_pkg::QueueDepth];
    logic [sha_pkg::QueueAw-1:0]    wr_reg, rd_reg;
    logic [sha_pkg::QueueAw:0]      cnt_reg;

    assign full     = (cnt_reg == (sha_pkg::QueueAw+1)'(sha_pkg::QueueDepth));
    assign empty    = (cnt_reg == '0);
    assign pop_item = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (sha_pkg::QueueAw+1)'(push) - (sha_pkg::QueueAw+1)'(pop);
        end
    end
endmodule

FILE: hdl/sha_engine.sv
// ============================================================================
// sha_engine: block assembly, padding, compression and digest output
// Packs bytes into 16 message words, runs 64 rounds one per cycle with an
// in-place 16-word schedule, pads at end of message and emits the digest.
// ============================================================================
module sha_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  sha_pkg::item_t item,
    output logic           item_pop,
    sha_out_if.source      out
);
    typedef enum logic [2:0] {
        ST_TAKE, ST_PAD, ST_ROUND, ST_ADD, ST_EMIT
    } state_t;

    state_t              state_reg;
    sha_pkg::word_t      h_reg [8];
    sha_pkg::word_t      v_reg [8];
    sha_pkg::word_t      w_reg [16];
    logic [5:0]          pos_reg;     // bytes in block
    logic [63:0]         len_reg;
    logic [5:0]          rnd_reg;
    logic                fin_reg;     // last item taken carried the end mark
    logic                last_reg;    // final padded block
    logic                mark_reg;    // marker byte still to append
    logic [2:0]          idx_reg;

    sha_pkg::word_t s0, s1, t1, t2, wcur, wnew;

    always_comb
    begin
        wcur = w_reg[0];
        s0   = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        t1   = v_reg[7] + (sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
               ^ sha_pkg::rotr(v_reg[4], 25)) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
               + sha_pkg::RoundK[rnd_reg] + wcur;
        t2   = (sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
               ^ sha_pkg::rotr(v_reg[0], 22))
               + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign item_pop        = (state_reg == ST_TAKE) && item_valid;
    assign out.valid       = (state_reg == ST_EMIT);
    assign out.digest_word = h_reg[idx_reg];
    assign out.word_index  = idx_reg;
    assign out.last_word   = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_TAKE;
            pos_reg   <= '0;
            len_reg   <= '0;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            last_reg  <= 1'b0;
            mark_reg  <= 1'b0;
            idx_reg   <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::init_word(3'(i));
            for (int i = 0; i < 8; i++) v_reg[i] <= '0;
            for (int i = 0; i < 16; i++) w_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_TAKE:
                begin
                    if (item_valid)
                    begin
                        if (item.byte_present)
                        begin
                            len_reg <= len_reg + 64'd8;
                        end
                        fin_reg <= item.end_of_message;
                        if (item.byte_present && pos_reg == 6'd63)
                        begin
                            w_reg[15] <= {w_reg[15][23:0], item.data_byte};
                            pos_reg   <= '0;
                            mark_reg  <= item.end_of_message;
                            last_reg  <= 1'b0;
                            rnd_reg   <= '0;
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                            state_reg <= ST_ROUND;
                        end
                        else if (item.end_of_message)
                        begin
                            // append the marker byte after the byte, if any
                            if (item.byte_present && pos_reg[1:0] == 2'd3)
                            begin
                                w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][23:0],
                                                        item.data_byte};
                                w_reg[pos_reg[5:2] + 4'd1] <=
                                    {w_reg[pos_reg[5:2] + 4'd1][23:0], 8'h80};
                            end
                            else if (item.byte_present)
                            begin
                                w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][15:0],
                                                        item.data_byte, 8'h80};
                            end
                            else
                            begin
                                w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][23:0], 8'h80};
                            end
                            pos_reg <= pos_reg + (item.byte_present ? 6'd2 : 6'd1);
                            // marker closes the block: compress it, length goes in the next
                            if (item.byte_present ? (pos_reg == 6'd62) : (pos_reg == 6'd63))
                            begin
                                last_reg  <= 1'b0;
                                rnd_reg   <= '0;
                                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                                state_reg <= ST_ROUND;
                            end
                            else
                            begin
                                state_reg <= ST_PAD;
                            end
                        end
                        else if (item.byte_present)
                        begin
                            w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][23:0], item.data_byte};
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                ST_PAD:
                begin
                    if (mark_reg)
                    begin
                        // marker opens the block after a full final block
                        w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][23:0], 8'h80};
                        pos_reg  <= pos_reg + 6'd1;
                        mark_reg <= 1'b0;
                    end
                    // shift zeros until word aligned, then zero words / length
                    else if (pos_reg[1:0] != 2'd0)
                    begin
                        w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][23:0], 8'h00};
                        pos_reg <= pos_reg + 6'd1;
                        if (pos_reg == 6'd63)
                        begin
                            rnd_reg <= '0;
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                            last_reg  <= 1'b0;
                            state_reg <= ST_ROUND;
                        end
                    end
                    else
                    begin
                        if (pos_reg[5:2] == 4'd14)
                        begin
                            w_reg[14] <= len_reg[63:32];
                            w_reg[15] <= len_reg[31:0];
                            pos_reg   <= '0;
                            rnd_reg   <= '0;
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                            last_reg  <= 1'b1;
                            state_reg <= ST_ROUND;
                        end
                        else
                        begin
                            w_reg[pos_reg[5:2]] <= '0;
                            pos_reg <= pos_reg + 6'd4;
                            if (pos_reg[5:2] == 4'd15)
                            begin
                                rnd_reg <= '0;
                                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                                last_reg  <= 1'b0;
                                state_reg <= ST_ROUND;
                            end
                        end
                    end
                end
                ST_ROUND:
                begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wnew;
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    rnd_reg  <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63) state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    idx_reg <= '0;
                    if (last_reg)         state_reg <= ST_EMIT;
                    else if (fin_reg)     state_reg <= ST_PAD;
                    else                  state_reg <= ST_TAKE;
                end
                ST_EMIT:
                begin
                    if (out.ready)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::init_word(3'(i));
                            len_reg   <= '0;
                            pos_reg   <= '0;
                            fin_reg   <= 1'b0;
                            last_reg  <= 1'b0;
                            state_reg <= ST_TAKE;
                        end
                    end
                end
                default: state_reg <= ST_TAKE;
            endcase
        end
    end
endmodule

FILE: hdl/sha256_stream_hasher.sv
// ============================================================================
// sha256_stream_hasher: SHA-256 over a byte stream
// Top level: input queue in front of the hashing engine.
// ============================================================================
// Usage:
//   in  : one transaction per item: an optional byte (byte_present) and an
//         end_of_message mark. Items enter a 4-entry queue, so the source is
//         taken at one item per cycle until the queue fills.
//   out : eight transactions per message, H0 first, last_word on H7.
// Throughput: the engine takes one byte per cycle; a full block then goes
//   through compression (one round per cycle plus the final add), during
//   which no byte is consumed. End of message costs the padding steps
//   plus one or two compressions, then the eight output transactions.
// Reset puts the initial hash values in place and empties the queue.
// A stalled receiver holds the current digest word; the queue keeps filling
//   until full, then ready drops.
// ============================================================================
module sha256_stream_hasher (
    input  logic      clk,
    input  logic      rst_n,
    sha_in_if.sink    in,
    sha_out_if.source out
);
    sha_pkg::item_t push_item, pop_item;
    logic           full, empty, pop;

    assign push_item = '{data_byte: in.data_byte, byte_present: in.byte_present,
                         end_of_message: in.end_of_message};
    assign in.ready  = !full;

    sha_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in.valid && !full),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    sha_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (!empty),
        .item       (pop_item),
        .item_pop   (pop),
        .out        (out)
    );
endmodule

FILE: dv/tb_sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher: self-checking testbench for the SHA-256 hasher
// Streams byte messages into the hasher under varying source and sink idling.
// An independent SHA-256 model predicts the eight digest words of every
// message, and the monitor compares each output transaction with them in order.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 4000;
    localparam int DrainCycles = 200;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    localparam logic [31:0] ShaK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] ShaIv [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic clk;
    logic rst_n;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hasher u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source)
    );

    sha_pkg::item_t byte_stream_q [$];
    digest_beat_t   digest_q [$];
    int             send_idle_pct;
    int             sink_stall_pct;
    bit             hold_send;
    int             error_count;
    int             quiet_cycles;

    // running hash state of the predictor
    logic [31:0] run_hash [8];
    logic [7:0]  msg_block [64];
    int          block_fill;
    logic [63:0] msg_bits;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            run_hash[i] = ShaIv[i];
        end
        block_fill = 0;
        msg_bits = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int r = 0; r < 16; r++)
        begin
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        end
        for (int r = 16; r < 64; r++)
        begin
            w[r] = w[r-16] + w[r-7]
                 + (ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3))
                 + (ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10));
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = run_hash[i];
        end
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ShaK[r] + w[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            run_hash[i] = run_hash[i] + v[i];
        end
    endtask

    // absorb one accepted transaction; on end of message queue the digest
    task automatic absorb_item(input sha_pkg::item_t it);
        digest_beat_t beat;
        int pos;
        if (it.byte_present)
        begin
            msg_block[block_fill] = it.data_byte;
            block_fill++;
            msg_bits = msg_bits + 64'd8;
            if (block_fill == 64)
            begin
                compress_block();
                block_fill = 0;
            end
        end
        if (it.end_of_message)
        begin
            pos = block_fill;
            msg_block[pos] = 8'h80;
            pos++;
            // no room for the length: spill into an extra block
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    msg_block[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56)
            begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
            begin
                msg_block[56+i] = msg_bits[63-8*i -: 8];
            end
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                beat.word = run_hash[i];
                beat.index = 3'(i);
                beat.last = (i == 7);
                digest_q.push_back(beat);
            end
            restart_hash();
        end
    endtask

    task automatic queue_item(input logic [7:0] b, input logic has_byte, input logic eom);
        sha_pkg::item_t it;
        it.data_byte = b;
        it.byte_present = has_byte;
        it.end_of_message = eom;
        byte_stream_q.push_back(it);
    endtask

    // one message; the end mark rides on the last byte or comes on its own
    task automatic queue_message(input int len, input bit end_on_byte, input int noise_pct);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                queue_item(8'($urandom), 1'b0, 1'b0);
            end
            queue_item(8'($urandom), 1'b1, (end_on_byte && i == len - 1));
        end
        if (!end_on_byte || len == 0)
        begin
            queue_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic wait_drained();
        while (byte_stream_q.size() != 0 || in_ch.valid || digest_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int msgs);
        int len;
        @(negedge clk);
        send_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        for (int m = 0; m < msgs; m++)
        begin
            len = $urandom_range(6);
            queue_message(len, $urandom_range(1), 10);
            // broken-up traffic: stray empty transactions between messages
            if ($urandom_range(3) == 0)
            begin
                queue_item(8'($urandom), 1'b0, 1'b0);
            end
        end
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= '0;
            in_ch.byte_present <= 1'b0;
            in_ch.end_of_message <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (byte_stream_q.size() != 0 && !hold_send
                && $urandom_range(99) >= send_idle_pct)
            begin
                in_ch.valid <= 1'b1;
                in_ch.data_byte <= byte_stream_q[0].data_byte;
                in_ch.byte_present <= byte_stream_q[0].byte_present;
                in_ch.end_of_message <= byte_stream_q[0].end_of_message;
                void'(byte_stream_q.pop_front());
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin
        sha_pkg::item_t it;
        digest_beat_t exp_beat;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                it.data_byte = in_ch.data_byte;
                it.byte_present = in_ch.byte_present;
                it.end_of_message = in_ch.end_of_message;
                absorb_item(it);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest word: actual %h idx %0d last %0b",
                             $time, out_ch.digest_word, out_ch.word_index, out_ch.last_word);
                    error_count++;
                end
                else
                begin
                    exp_beat = digest_q.pop_front();
                    if (out_ch.digest_word !== exp_beat.word)
                    begin
                        $display("%0t: digest_word mismatch: expected %h actual %h",
                                 $time, exp_beat.word, out_ch.digest_word);
                        error_count++;
                    end
                    if (out_ch.word_index !== exp_beat.index)
                    begin
                        $display("%0t: word_index mismatch: expected %0d actual %0d",
                                 $time, exp_beat.index, out_ch.word_index);
                        error_count++;
                    end
                    if (out_ch.last_word !== exp_beat.last)
                    begin
                        $display("%0t: last_word mismatch: expected %0b actual %0b",
                                 $time, exp_beat.last, out_ch.last_word);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit)
            begin
                $display("tb_sha256_stream_hasher failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        hold_send = 1'b0;
        error_count = 0;
        quiet_cycles = 0;
        restart_hash();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, byte with end, end after bytes, field extremes
        queue_item(8'h00, 1'b0, 1'b1);
        queue_item(8'hff, 1'b1, 1'b1);
        queue_item(8'h00, 1'b1, 1'b1);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h5a, 1'b0, 1'b0);
        queue_item(8'h63, 1'b1, 1'b0);
        queue_item(8'ha5, 1'b0, 1'b1);
        queue_item(8'hff, 1'b1, 1'b0);
        queue_item(8'h00, 1'b1, 1'b0);
        queue_item(8'h80, 1'b1, 1'b1);
        queue_item(8'hff, 1'b0, 1'b1);
        wait_drained();

        run_random_phase(0, 0, 2);
        run_random_phase(68, 0, 2);

        // hold the source back with a message queued, then release it
        @(negedge clk);
        hold_send = 1'b1;
        queue_message(3, 1'b1, 0);
        repeat (20) @(negedge clk);
        hold_send = 1'b0;
        wait_drained();

        run_random_phase(0, 68, 2);
        run_random_phase(38, 38, 2);

        // padding boundary: no room for the length, spill into an extra block
        @(negedge clk);
        queue_message(60, 1'b1, 0);
        wait_drained();

        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_sha256_stream_hasher passed");
        end
        else
        begin
            $display("tb_sha256_stream_hasher failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/sha_pkg.sv
hdl/sha_in_if.sv
hdl/sha_out_if.sv
hdl/sha_queue.sv
hdl/sha_engine.sv
hdl/sha256_stream_hasher.sv
dv/tb_sha256_stream_hasher.sv
